// ===== rtl/core/plt_pkg.sv =====
// Shared types and codes of the pending lookup table.
`timescale 1ns / 1ps

package plt_pkg;

  // One stored message.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [15:0] msg_key;
    logic [15:0] origin_id;
    logic [31:0] origin_ip;
    logic [15:0] origin_port;
  } plt_entry_t;

  // Request commands.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_UPDATED  = 3'd0;
  localparam logic [2:0] STAT_APPENDED = 3'd1;
  localparam logic [2:0] STAT_EVICTED  = 3'd2;
  localparam logic [2:0] STAT_FOUND    = 3'd3;
  localparam logic [2:0] STAT_NONE     = 3'd4;

  // Type byte of a reply that a find may take.
  localparam logic [7:0] REPLY_TYPE = 8'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_WRITE,
    ST_FIN
  } plt_state_t;

endpackage

// ===== rtl/core/plt_table.sv =====
// Entry store of the pending lookup table: one write port, one registered read port.
`timescale 1ns / 1ps

module plt_table import plt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  plt_entry_t       wdata,
  input  logic [IDX_W-1:0] raddr,
  output plt_entry_t       rdata
);

  plt_entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/plt_match.sv =====
// Shared entry compare unit: add match on key and origin, or find on the reply ring interval.
`timescale 1ns / 1ps

module plt_match import plt_pkg::*; (
  input  logic        command,
  input  plt_entry_t  entry,
  input  logic [15:0] msg_key,
  input  logic [15:0] origin_id,
  output logic        match
);

  logic [15:0] pred;
  logic [15:0] node;
  logic        in_ring;

  assign pred = entry.msg_key;
  assign node = entry.origin_id;

  // Interval (pred, node] on the key ring; equal ends cover the whole ring.
  always_comb begin
    if (pred < node) begin
      in_ring = (msg_key > pred) && (msg_key <= node);
    end else if (pred > node) begin
      in_ring = (msg_key > pred) || (msg_key <= node);
    end else begin
      in_ring = 1'b1;
    end
  end

  always_comb begin
    case (command)
      CMD_ADD:  match = (entry.msg_key == msg_key) && (entry.origin_id == origin_id);
      CMD_FIND: match = (entry.msg_type == REPLY_TYPE) && in_ring;
      default:  match = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/pending_lookup_table.sv =====
// Top level of the pending lookup table: sequencer, fill count and result register.
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------------
// in       in_valid / in_ready  command, msg_type, msg_key, origin_id, origin_ip,
//                               origin_port
// out      out_valid / out_ready status, out_type, out_key, out_origin_id,
//                               out_origin_ip, out_origin_port, fill
//
// One word takes an accept step, a scan through the single read port of the entry
// store (none on an empty table), a copy of one entry per cycle when an entry is
// removed or the oldest is evicted, a write for an add, and a finish step.
// Reset clears the fill count and the sequencer; the entry store keeps no reset.
// in_ready is high only in the idle state. A finished result waits in the output
// register, so the next word is taken while out_ready is low; a second finished
// result then holds in the finish state until the output register frees.

module pending_lookup_table import plt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  msg_type,
  input  logic [15:0] msg_key,
  input  logic [15:0] origin_id,
  input  logic [31:0] origin_ip,
  input  logic [15:0] origin_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  out_type,
  output logic [15:0] out_key,
  output logic [15:0] out_origin_id,
  output logic [31:0] out_origin_ip,
  output logic [15:0] out_origin_port,
  output logic [4:0]  fill
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

  // Sequencer and request registers.
  plt_state_t       state, state_next;
  logic             req_cmd, req_cmd_next;
  plt_entry_t       req_entry, req_entry_next;
  logic [CNT_W-1:0] idx, idx_next;            // next address to read in scan
  logic             cmp_vld, cmp_vld_next;    // read data in flight is valid
  logic [IDX_W-1:0] cmp_idx, cmp_idx_next;    // address of the data in flight
  logic [IDX_W-1:0] sidx, sidx_next;          // copy destination cursor
  logic [IDX_W-1:0] last_idx, last_idx_next;  // copy ends when the cursor reaches it
  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  logic [2:0]       res_status, res_status_next;
  plt_entry_t       res_entry, res_entry_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;

  // Output register.
  logic             out_valid_next;
  logic [2:0]       status_next;
  plt_entry_t       out_entry, out_entry_next;
  logic [4:0]       fill_next;

  // Entry store ports.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  plt_entry_t       mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  plt_entry_t       mem_rdata;

  logic             hit;
  logic [IDX_W-1:0] fill_last;

  plt_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // One compare unit serves every scan step, for both commands.
  plt_match u_match (
    .command  (req_cmd),
    .entry    (mem_rdata),
    .msg_key  (req_entry.msg_key),
    .origin_id(req_entry.origin_id),
    .match    (hit)
  );

  assign fill_last = IDX_W'(fill_count - CNT_W'(1));
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cmp_vld    <= 1'b0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cmp_vld    <= cmp_vld_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    req_cmd    <= req_cmd_next;
    req_entry  <= req_entry_next;
    idx        <= idx_next;
    cmp_idx    <= cmp_idx_next;
    sidx       <= sidx_next;
    last_idx   <= last_idx_next;
    wr_idx     <= wr_idx_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    status     <= status_next;
    out_entry  <= out_entry_next;
    fill       <= fill_next;
  end

  always_comb begin
    state_next      = state;
    req_cmd_next    = req_cmd;
    req_entry_next  = req_entry;
    idx_next        = idx;
    cmp_vld_next    = cmp_vld;
    cmp_idx_next    = cmp_idx;
    sidx_next       = sidx;
    last_idx_next   = last_idx;
    wr_idx_next     = wr_idx;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    fill_count_next = fill_count;
    out_valid_next  = out_valid;
    status_next     = status;
    out_entry_next  = out_entry;
    fill_next       = fill;

    mem_we    = 1'b0;
    mem_waddr = wr_idx;
    mem_wdata = req_entry;
    mem_raddr = idx[IDX_W-1:0];

    // Drop the held result once taken.
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_cmd_next   = command;
          req_entry_next = '{msg_type, msg_key, origin_id, origin_ip, origin_port};
          idx_next       = '0;
          cmp_vld_next   = 1'b0;
          res_entry_next = '0;
          if (fill_count == '0) begin
            // Empty table: append straight away, or report nothing found.
            if (command == CMD_ADD) begin
              wr_idx_next     = '0;
              res_status_next = STAT_APPENDED;
              state_next      = ST_WRITE;
            end else begin
              res_status_next = STAT_NONE;
              state_next      = ST_FIN;
            end
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Read one entry a cycle, oldest first; compare what arrived last cycle.
        mem_raddr = idx[IDX_W-1:0];
        if (cmp_vld && hit) begin
          cmp_vld_next = 1'b0;
          if (req_cmd == CMD_ADD) begin
            wr_idx_next     = cmp_idx;
            res_status_next = STAT_UPDATED;
            state_next      = ST_WRITE;
          end else begin
            res_entry_next  = mem_rdata;
            res_status_next = STAT_FOUND;
            sidx_next       = cmp_idx;
            last_idx_next   = fill_last;
            state_next      = ST_SHIFT;
          end
        end else if (cmp_vld && (cmp_idx == fill_last)) begin
          cmp_vld_next = 1'b0;
          if (req_cmd == CMD_ADD) begin
            if (fill_count < DEPTH_CNT) begin
              wr_idx_next     = IDX_W'(fill_count);
              res_status_next = STAT_APPENDED;
              state_next      = ST_WRITE;
            end else begin
              // Full: move everything one place forward, then write the last slot.
              wr_idx_next     = LAST_IDX;
              res_status_next = STAT_EVICTED;
              sidx_next       = '0;
              last_idx_next   = LAST_IDX;
              state_next      = ST_SHIFT;
            end
          end else begin
            res_status_next = STAT_NONE;
            state_next      = ST_FIN;
          end
        end else begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = idx[IDX_W-1:0];
          idx_next     = idx + CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        // Read entry sidx+1 and write it to sidx in the next cycle.
        mem_raddr = sidx + IDX_W'(1);
        if (cmp_vld) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx;
          mem_wdata = mem_rdata;
        end
        if (sidx < last_idx) begin
          cmp_vld_next = 1'b1;
          cmp_idx_next = sidx;
          sidx_next    = sidx + IDX_W'(1);
        end else begin
          cmp_vld_next = 1'b0;
          if (res_status == STAT_EVICTED) begin
            state_next = ST_WRITE;
          end else begin
            fill_count_next = fill_count - CNT_W'(1);
            state_next      = ST_FIN;
          end
        end
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_idx;
        mem_wdata = req_entry;
        if (res_status == STAT_APPENDED) begin
          fill_count_next = fill_count + CNT_W'(1);
        end
        state_next = ST_FIN;
      end

      ST_FIN: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          status_next    = res_status;
          out_entry_next = res_entry;
          fill_next      = 5'(fill_count);
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_type        = out_entry.msg_type;
  assign out_key         = out_entry.msg_key;
  assign out_origin_id   = out_entry.origin_id;
  assign out_origin_ip   = out_entry.origin_ip;
  assign out_origin_port = out_entry.origin_port;

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_CNT)
    else $error("fill count above table depth");

  // A found entry is always a reply.
  a_found_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STAT_FOUND)) |-> (out_type == REPLY_TYPE))
    else $error("found entry is not a reply");

  // Only a found result carries entry fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_FOUND)) |-> (out_entry == '0))
    else $error("entry fields set without a found entry");

  // An accepted word keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");
`endif

endmodule

// ===== tb/sv/pending_lookup_table_test.sv =====
// Self-checking testbench of the pending lookup table against a shadow table in the bench.
`timescale 1ns / 1ps

module pending_lookup_table_test;
  import plt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic       cmd;
    plt_entry_t msg;
  } request_t;

  typedef struct {
    logic [2:0] status;
    plt_entry_t entry;
    logic [4:0] fill;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_ADD;
  logic [7:0]  msg_type = '0;
  logic [15:0] msg_key = '0;
  logic [15:0] origin_id = '0;
  logic [31:0] origin_ip = '0;
  logic [15:0] origin_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  out_type;
  logic [15:0] out_key;
  logic [15:0] out_origin_id;
  logic [31:0] out_origin_ip;
  logic [15:0] out_origin_port;
  logic [4:0]  fill;

  // Shadow copy of the table, advanced once per accepted request word.
  plt_entry_t shadow_entries [DEPTH];
  int         shadow_fill = 0;
  outcome_t   awaited_results [$];

  int mismatches   = 0;
  int cycles       = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_left = 0;

  pending_lookup_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .msg_type        (msg_type),
    .msg_key         (msg_key),
    .origin_id       (origin_id),
    .origin_ip       (origin_ip),
    .origin_port     (origin_port),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .out_type        (out_type),
    .out_key         (out_key),
    .out_origin_id   (out_origin_id),
    .out_origin_ip   (out_origin_ip),
    .out_origin_port (out_origin_port),
    .fill            (fill)
  );

  always #5 clk = ~clk;

  // Stop a hung run; the limit is several times the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Ring interval (lo, hi] on the 16-bit key circle; equal ends cover the whole ring.
  function automatic bit key_in_arc(logic [15:0] key, logic [15:0] lo, logic [15:0] hi);
    if (lo < hi) return (key > lo) && (key <= hi);
    if (lo > hi) return (key > lo) || (key <= hi);
    return 1'b1;
  endfunction

  // Advance the shadow table by one request and return the result word it must produce.
  function automatic outcome_t apply_request(request_t req);
    outcome_t res;
    int       hit;
    res.status = STAT_NONE;
    res.entry  = '0;
    hit        = -1;
    if (req.cmd == CMD_ADD) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (hit < 0 && shadow_entries[i].msg_key == req.msg.msg_key &&
            shadow_entries[i].origin_id == req.msg.origin_id) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        shadow_entries[hit] = req.msg;
        res.status = STAT_UPDATED;
      end else if (shadow_fill < DEPTH) begin
        shadow_entries[shadow_fill] = req.msg;
        shadow_fill++;
        res.status = STAT_APPENDED;
      end else begin
        // Drop the oldest, move the rest forward, put the new message last.
        for (int j = 0; j < DEPTH - 1; j++) shadow_entries[j] = shadow_entries[j + 1];
        shadow_entries[DEPTH - 1] = req.msg;
        res.status = STAT_EVICTED;
      end
    end else begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (hit < 0 && shadow_entries[i].msg_type == REPLY_TYPE &&
            key_in_arc(req.msg.msg_key, shadow_entries[i].msg_key,
                       shadow_entries[i].origin_id)) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        res.entry = shadow_entries[hit];
        // Close the gap behind the removed entry.
        for (int j = hit; j < shadow_fill - 1; j++) shadow_entries[j] = shadow_entries[j + 1];
        shadow_fill--;
        res.status = STAT_FOUND;
      end
    end
    res.fill = 5'(shadow_fill);
    return res;
  endfunction

  // Offer one request word, hold it until accepted, then idle at random.
  task automatic send_word(request_t req);
    int gap;
    in_valid    <= 1'b1;
    command     <= req.cmd;
    msg_type    <= req.msg.msg_type;
    msg_key     <= req.msg.msg_key;
    origin_id   <= req.msg.origin_id;
    origin_ip   <= req.msg.origin_ip;
    origin_port <= req.msg.origin_port;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(apply_request(req));
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t make_request(logic cmd, logic [7:0] typ, logic [15:0] key,
                                            logic [15:0] id, logic [31:0] ip,
                                            logic [15:0] port);
    request_t req;
    req.cmd             = cmd;
    req.msg.msg_type    = typ;
    req.msg.msg_key     = key;
    req.msg.origin_id   = id;
    req.msg.origin_ip   = ip;
    req.msg.origin_port = port;
    return req;
  endfunction

  // Keys cluster around the wrap point so ring intervals wrap and adds collide.
  function automatic logic [15:0] pick_key();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'(16'hFFF8 + $urandom_range(15));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom());
      default: return REPLY_TYPE;
    endcase
  endfunction

  function automatic request_t random_request(int add_pct);
    request_t req;
    int       pick;
    req = make_request(($urandom_range(99) < add_pct) ? CMD_ADD : CMD_FIND, pick_type(),
                       pick_key(), pick_key(), $urandom(), 16'($urandom()));
    // Reuse a stored key and id now and then so updates actually happen.
    if (req.cmd == CMD_ADD && shadow_fill > 0 && $urandom_range(4) == 0) begin
      pick = $urandom_range(shadow_fill - 1);
      req.msg.msg_key   = shadow_entries[pick].msg_key;
      req.msg.origin_id = shadow_entries[pick].origin_id;
    end
    return req;
  endfunction

  // Receiver: random stalls, plus a long hold-off counted down here when requested.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h (cycle %0d)", what, want, got, cycles);
  endtask

  // Check each result word against the oldest outstanding prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: status %h fill %h (cycle %0d)",
                   status, fill, cycles);
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(status));
        if (out_type !== want.entry.msg_type)
          note_mismatch("out_type", 32'(want.entry.msg_type), 32'(out_type));
        if (out_key !== want.entry.msg_key)
          note_mismatch("out_key", 32'(want.entry.msg_key), 32'(out_key));
        if (out_origin_id !== want.entry.origin_id)
          note_mismatch("out_origin_id", 32'(want.entry.origin_id), 32'(out_origin_id));
        if (out_origin_ip !== want.entry.origin_ip)
          note_mismatch("out_origin_ip", want.entry.origin_ip, out_origin_ip);
        if (out_origin_port !== want.entry.origin_port)
          note_mismatch("out_origin_port", 32'(want.entry.origin_port),
                        32'(out_origin_port));
        if (fill !== want.fill) note_mismatch("fill", 32'(want.fill), 32'(fill));
      end
    end
  end

  // A find on an empty table returns nothing and zeros.
  task automatic test_find_empty();
    send_word(make_request(CMD_FIND, 8'hFF, 16'h1234, 16'hFFFF, '1, '1));
  endtask

  // All-ones and all-zero messages; neither is a reply, so finds must skip them.
  task automatic test_field_extremes();
    send_word(make_request(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_request(CMD_ADD, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000));
  endtask

  // Same key and origin id overwrite in place.
  task automatic test_update();
    send_word(make_request(CMD_ADD, 8'h5A, 16'hFFFF, 16'hFFFF, 32'h0BAD_F00D, 16'h1F90));
  endtask

  // Plain, wrapping and full-ring intervals, probed at their ends.
  task automatic test_ring_intervals();
    send_word(make_request(CMD_ADD, REPLY_TYPE, 16'd10, 16'd20, 32'hC0A8_0001, 16'd4000));
    send_word(make_request(CMD_ADD, REPLY_TYPE, 16'hFFF0, 16'd5, 32'hC0A8_0002, 16'd4001));
    send_word(make_request(CMD_ADD, REPLY_TYPE, 16'd100, 16'd100, 32'hC0A8_0003, 16'd4002));
    send_word(make_request(CMD_ADD, REPLY_TYPE, 16'hFFF0, 16'd6, 32'hC0A8_0004, 16'd4003));
    // Lower end excluded: only the full-ring entry takes key 10.
    send_word(make_request(CMD_FIND, 8'h00, 16'd10, 16'h0000, '0, '0));
    // Upper end included.
    send_word(make_request(CMD_FIND, 8'h00, 16'd20, 16'h0000, '0, '0));
    // Wrapping interval: its lower end is excluded, the top of the ring is included.
    send_word(make_request(CMD_FIND, 8'h00, 16'hFFF0, 16'h0000, '0, '0));
    send_word(make_request(CMD_FIND, 8'h00, 16'hFFFF, 16'h0000, '0, '0));
    send_word(make_request(CMD_FIND, 8'h00, 16'd6, 16'h0000, '0, '0));
  endtask

  // Fill the table, evict the oldest, then update while full.
  task automatic test_full_table();
    int n;
    n = 0;
    while (shadow_fill < DEPTH) begin
      send_word(make_request(CMD_ADD, (n % 2 == 0) ? REPLY_TYPE : 8'h80,
                             16'(16'h1000 + n), 16'(16'h2000 + n), 32'(n), 16'(n)));
      n++;
    end
    send_word(make_request(CMD_ADD, 8'h22, 16'h3000, 16'h3001, 32'h8000_0000, 16'h8000));
    send_word(make_request(CMD_ADD, 8'h23, 16'h3000, 16'h3001, 32'h7FFF_FFFF, 16'h7FFF));
  endtask

  // Random traffic in bursts that lean to adds or to finds so the fill swings.
  task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
    int add_pct;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    add_pct     = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 85;
          1:       add_pct = 50;
          default: add_pct = 25;
        endcase
      end
      send_word(random_request(add_pct));
    end
  endtask

  // Hold off the receiver for a long stretch while words keep coming, so the block stalls.
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_word(random_request(60));
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_find_empty();
    test_field_extremes();
    test_update();
    test_ring_intervals();
    test_full_table();
    test_random_traffic(630, 23, 73);
    test_random_traffic(630, 73, 23);
    test_output_backpressure();
    test_random_traffic(630, 0, 0);
    finish_run();
  end

endmodule

// ===== filelist.f =====
rtl/core/plt_pkg.sv
rtl/core/plt_table.sv
rtl/core/plt_match.sv
rtl/core/pending_lookup_table.sv
tb/sv/pending_lookup_table_test.sv
